// ===== hw/rtl/pnrf_pkg.sv =====
// Package with types and constants shared by the Newton root finder files.
`default_nettype none
package pnrf_pkg;
   localparam int MaxDegreeDefault = 7;
   localparam int MaxIterationsDefault = 64;
   localparam int FracBitsDefault = 16;
   localparam int DataWidth = 32;
   localparam int CsrIndexWidth = 1;
   localparam int CsrDataWidth = 31;
   localparam logic [CsrIndexWidth-1:0] CSR_DEGREE = 1'b0;
   localparam logic [CsrIndexWidth-1:0] CSR_TOLERANCE = 1'b1;
   localparam logic [1:0] STATUS_CONVERGED = 2'd0;
   localparam logic [1:0] STATUS_ZERO_DERIV = 2'd1;
   localparam logic [1:0] STATUS_ITER_LIMIT = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE, ST_CLEAR, ST_INIT, ST_FREAD, ST_FMUL, ST_FACC, ST_DREAD, ST_DSCALE,
      ST_DMUL, ST_DACC, ST_CHECK, ST_DIV, ST_UPDATE, ST_DONE
   } state_type;

   function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
      if (v > 72'sd2147483647) return 32'sh7fffffff;
      else if (v < -72'sd2147483648) return 32'sh80000000;
      else return v[31:0];
   endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/pnrf_ram.sv =====
// Generic RAM with one write port and one registered read port.
`default_nettype none
module pnrf_ram #(
   parameter int Width = 32,
   parameter int Depth = 8
) (
   input  wire                     clock,
   input  wire                     wr_en,
   input  wire [$clog2(Depth)-1:0] wr_addr,
   input  wire [Width-1:0]         wr_data,
   input  wire [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]        rd_data
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ===== hw/rtl/pnrf_div.sv =====
// Serial restoring divider: signed quotient of (num << FracBits) / den, truncated.
`default_nettype none
module pnrf_div import pnrf_pkg::*; #(
   parameter int FracBits = FracBitsDefault
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                start,
   input  wire signed [31:0]  num,
   input  wire signed [31:0]  den,
   output logic               done,
   output logic signed [31:0] quot
);
   localparam int NW = 32 + FracBits;
   localparam int CW = $clog2(NW + 1);
   logic [NW-1:0] dividend_ff, dividend_in;
   logic [NW-1:0] quo_ff, quo_in;
   logic [NW:0]   rem_ff, rem_in;
   logic [31:0]   den_ff, den_in;
   logic          neg_ff, neg_in;
   logic [CW-1:0] count_ff, count_in;
   logic          run_ff, run_in;
   logic [NW:0]   trial;
   logic signed [NW+1:0] signed_q;

   always_comb begin
      dividend_in = dividend_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      neg_in = neg_ff;
      count_in = count_ff;
      run_in = run_ff;
      trial = {rem_ff[NW-1:0], dividend_ff[NW-1]} - {{(NW-31){1'b0}}, den_ff};
      if (start) begin
         dividend_in = num[31] ? NW'(-({{FracBits{num[31]}}, num} <<< FracBits))
                               : NW'({{FracBits{1'b0}}, num} << FracBits);
         den_in = den[31] ? 32'(-den) : den;
         neg_in = num[31] ^ den[31];
         rem_in = '0;
         quo_in = '0;
         count_in = CW'(NW);
         run_in = 1'b1;
      end else if (run_ff) begin
         dividend_in = dividend_ff << 1;
         if (!trial[NW]) begin
            rem_in = trial;
            quo_in = {quo_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[NW-1:0], dividend_ff[NW-1]};
            quo_in = {quo_ff[NW-2:0], 1'b0};
         end
         count_in = count_ff - 1'b1;
         if (count_ff == CW'(1)) run_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      dividend_ff <= dividend_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
      count_ff <= count_in;
      if (reset) run_ff <= 1'b0;
      else run_ff <= run_in;
   end

   assign done = run_ff && (count_ff == CW'(1));
   always_comb begin
      signed_q = neg_ff ? -$signed({2'b00, quo_in}) : $signed({2'b00, quo_in});
      quot = sat32(72'(signed_q));
   end
endmodule
`default_nettype wire

// ===== hw/rtl/polynomial_newton_root_finder_core.sv =====
// Newton-Raphson polynomial root finder core, Q16.16 signed fixed point.
// A load beat writes one coefficient (indices above MaxDegree are dropped) and gives no result.
// Each Newton step evaluates f and its derivative by Horner's rule, checks the derivative,
// runs the serial divider and updates x; steps repeat until convergence or the iteration
// limit, and a zero derivative ends the solve early; one solve runs at a time.
// After reset the store is cleared one entry a cycle (all MaxDegree+1 entries), busy high.
// Results are shown for one cycle with rsp_valid; the receiver cannot stall.
`default_nettype none
module polynomial_newton_root_finder_core import pnrf_pkg::*; #(
   parameter int MaxDegree = MaxDegreeDefault,
   parameter int MaxIterations = MaxIterationsDefault,
   parameter int FracBits = FracBitsDefault
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     start,
   output logic                    busy,
   input  wire                     req_kind,
   input  wire [2:0]               req_coeff_index,
   input  wire signed [31:0]       req_coeff_value,
   input  wire signed [31:0]       req_start_x,
   output logic                    rsp_valid,
   output logic signed [31:0]      rsp_root,
   output logic [6:0]              rsp_iterations,
   output logic [1:0]              rsp_status,
   input  wire                     csr_write,
   input  wire [CsrIndexWidth-1:0] csr_index,
   input  wire [CsrDataWidth-1:0]  csr_data
);
   localparam int Depth = MaxDegree + 1;
   localparam int AW = $clog2(Depth);
   localparam int IW = $clog2(MaxIterations + 1);

   state_type state_ff, state_in;
   logic [2:0]  degree_ff;
   logic [30:0] tolerance_ff;
   logic [AW-1:0] idx_ff, idx_in, dlim;
   logic signed [31:0] x_ff, x_in, acc_ff, acc_in, f_ff, f_in, dc_ff, dc_in;
   logic signed [63:0] prod_ff, prod_in;
   logic [IW-1:0] n_ff, n_in;
   logic [1:0] status_ff, status_in;
   logic out_ff;
   logic we;
   logic [AW-1:0] waddr, raddr;
   logic [31:0] wdata, rdata;
   logic div_start, div_done;
   logic signed [31:0] quot;
   logic signed [32:0] mag;
   logic signed [71:0] ext;
   logic signed [AW+32:0] dscale;
   logic [3:0] d_eff;

   assign d_eff = ({1'b0, degree_ff} > 4'(MaxDegree)) ? 4'(MaxDegree) : {1'b0, degree_ff};
   assign dlim = AW'(d_eff);

   pnrf_ram #(.Width(32), .Depth(Depth)) u_store (
      .clock, .wr_en(we), .wr_addr(waddr), .wr_data(wdata), .rd_addr(raddr), .rd_data(rdata)
   );

   pnrf_div #(.FracBits(FracBits)) u_div (
      .clock, .reset, .start(div_start), .num(f_ff), .den(acc_ff), .done(div_done), .quot
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         degree_ff <= 3'd3;
         tolerance_ff <= 31'd1;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_DEGREE:    degree_ff <= csr_data[2:0];
            CSR_TOLERANCE: tolerance_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign busy = (state_ff != ST_IDLE);
   assign ext = 72'(prod_ff >>> FracBits);
   assign dscale = $signed(rdata) * $signed({1'b0, idx_ff});

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (start) state_in = req_kind ? ST_INIT : ST_IDLE;
         ST_CLEAR: if (idx_ff == AW'(MaxDegree)) state_in = ST_IDLE;
         ST_INIT: state_in = (d_eff == 4'd0) ? ST_DONE : ST_FREAD;
         ST_FREAD: state_in = ST_FACC;
         ST_FMUL: state_in = ST_FACC;
         ST_FACC: state_in = (idx_ff == '0) ? ST_DREAD : ST_FMUL;
         ST_DREAD: state_in = ST_DSCALE;
         ST_DSCALE: state_in = ST_DACC;
         ST_DMUL: state_in = ST_DREAD;
         ST_DACC: state_in = (idx_ff == AW'(1)) ? ST_CHECK : ST_DMUL;
         ST_CHECK: state_in = (acc_ff == 0) ? ST_DONE : ST_DIV;
         ST_DIV: if (div_done) state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_DONE;
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
      if (state_ff == ST_UPDATE && !((mag <= $signed({2'b0, tolerance_ff})) ||
          (n_ff + 1'b1 == IW'(MaxIterations))))
         state_in = ST_FREAD;
   end

   always_comb begin
      idx_in = idx_ff; x_in = x_ff; acc_in = acc_ff; f_in = f_ff; dc_in = dc_ff;
      prod_in = prod_ff; n_in = n_ff; status_in = status_ff;
      we = 1'b0; waddr = idx_ff; wdata = '0; raddr = idx_ff; div_start = 1'b0;
      mag = quot[31] ? -{quot[31], quot} : {quot[31], quot};
      unique case (state_ff)
         ST_IDLE: begin
            if (start && !req_kind && {1'b0, req_coeff_index} <= 4'(MaxDegree)) begin
               we = 1'b1; waddr = AW'(req_coeff_index); wdata = req_coeff_value;
            end
            x_in = req_start_x; n_in = '0; idx_in = dlim;
         end
         ST_CLEAR: begin
            we = 1'b1; idx_in = idx_ff + 1'b1;
         end
         ST_INIT: status_in = STATUS_ZERO_DERIV;
         ST_FREAD: begin
            raddr = dlim; idx_in = dlim;
            acc_in = '0; prod_in = '0;
         end
         ST_FMUL: prod_in = acc_ff * x_ff;
         ST_FACC: begin
            // The product is saturated on its own before the coefficient is added.
            acc_in = sat32(72'(sat32(ext)) + 72'(signed'(rdata)));
            if (idx_ff != '0) begin idx_in = idx_ff - 1'b1; raddr = idx_ff - 1'b1; end
            else begin idx_in = dlim; f_in = acc_in; acc_in = '0; prod_in = '0; end
         end
         ST_DREAD: raddr = idx_ff;
         ST_DSCALE: dc_in = sat32(72'(dscale));
         ST_DMUL: prod_in = acc_ff * x_ff;
         ST_DACC: begin
            acc_in = sat32(72'(sat32(ext)) + 72'(dc_ff));
            prod_in = '0;
            if (idx_ff != AW'(1)) idx_in = idx_ff - 1'b1;
         end
         ST_CHECK: begin
            if (acc_ff == 0) status_in = STATUS_ZERO_DERIV;
            else div_start = 1'b1;
         end
         ST_UPDATE: begin
            x_in = sat32(72'(x_ff) - 72'(quot));
            n_in = n_ff + 1'b1;
            if (mag <= $signed({2'b0, tolerance_ff})) status_in = STATUS_CONVERGED;
            else if (n_ff + 1'b1 == IW'(MaxIterations)) status_in = STATUS_ITER_LIMIT;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         idx_ff <= '0;
         out_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
         out_ff <= (state_ff == ST_DONE);
      end
      x_ff <= x_in;
      acc_ff <= acc_in; f_ff <= f_in; dc_ff <= dc_in;
      prod_ff <= prod_in; n_ff <= n_in;
      status_ff <= status_in;
   end

   assign rsp_valid = out_ff;
   assign rsp_root = x_ff;
   assign rsp_iterations = 7'(n_ff);
   assign rsp_status = status_ff;

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$past(rsp_valid)) else $error("result strobe held two cycles");
   a_iter_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_iterations <= 7'(MaxIterations))) else $error("iteration count over cap");
   a_limit_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_ITER_LIMIT) |-> (rsp_iterations == 7'(MaxIterations)))
      else $error("iteration limit status without full count");
endmodule
`default_nettype wire
